>>> src/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the column centroid binning block.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int unsigned RadiusBits   = 6;
  localparam int unsigned FracBits     = 4;
  localparam int unsigned StartQBits   = 14;
  localparam int unsigned MeanXYBits   = 16;
  localparam int unsigned MeanRBits    = 10;
  localparam int unsigned IntervalBits = 15;
  localparam logic [StartQBits-1:0] StartQReset = 14'd44;

  // Status of the shared divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> src/bcc_ram.sv
// ----------------------------------------------------------------------------
// bcc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bcc_ram #(
  parameter int unsigned Width = 30,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/bcc_div.sv
// ----------------------------------------------------------------------------
// bcc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcc_div #(
  parameter int unsigned Width = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [Width-1:0]    dividend_i,
  input  logic [Width-1:0]    divisor_i,
  output bcc_pkg::div_stat_t  stat_o,
  output logic [Width-1:0]    quot_o,
  output logic [Width-1:0]    rem_o
);

  localparam int unsigned CntW = $clog2(Width + 1);

  logic [Width-1:0] rem_q;
  logic [Width-1:0] quo_q;
  logic [Width-1:0] dvs_q;
  logic [CntW-1:0]  cnt_q;
  logic             done_q;
  logic [Width:0]   trial;

  assign trial = {rem_q, quo_q[Width-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && (cnt_q == CntW'(1));
      if (start_i) begin
        rem_q <= '0;
        quo_q <= dividend_i;
        dvs_q <= divisor_i;
        cnt_q <= CntW'(Width);
      end else if (cnt_q != '0) begin
        if (trial >= {1'b0, dvs_q}) begin
          rem_q <= Width'(trial - {1'b0, dvs_q});
          quo_q <= {quo_q[Width-2:0], 1'b1};
        end else begin
          rem_q <= trial[Width-1:0];
          quo_q <= {quo_q[Width-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;
  assign rem_o       = rem_q;

endmodule

>>> src/bin_points_column_centroids.sv
// ----------------------------------------------------------------------------
// bin_points_column_centroids
// Column binning of circle centres with per-bin mean x, y and radius.
// ----------------------------------------------------------------------------
// Loading: one point beat per cycle while busy_o is low; the closing beat sets busy_o.
// With N stored points, each bin search scans all N and then runs one division.
// An interval is accepted after its bins and one empty scan; MAX_GROUPS+1 searches reject it.
// Each result then costs a search, a sum scan over the N points and three divisions.
// The receiver cannot stall; busy_o drops with the strobe of the highest bin.
// Reset idles the sequencer, empties the point count and sets the start width to 44.
// ----------------------------------------------------------------------------
module bin_points_column_centroids #(
  parameter int unsigned MAX_POINTS = 256,
  parameter int unsigned MAX_GROUPS = 24,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [COORD_BITS-1:0]  x_coord_i,
  input  logic [COORD_BITS-1:0]  y_coord_i,
  input  logic [bcc_pkg::RadiusBits-1:0] radius_i,
  input  logic                   last_point_i,
  input  logic                   cfg_we_i,
  input  logic [bcc_pkg::StartQBits-1:0] cfg_wdata_i,
  output logic                   result_valid_o,
  output logic [bcc_pkg::MeanXYBits-1:0]   mean_x_o,
  output logic [bcc_pkg::MeanXYBits-1:0]   mean_y_o,
  output logic [bcc_pkg::MeanRBits-1:0]    mean_radius_o,
  output logic [bcc_pkg::IntervalBits-1:0] final_interval_q_o,
  output logic                   last_group_o
);

  localparam int unsigned RB  = bcc_pkg::RadiusBits;
  localparam int unsigned FB  = bcc_pkg::FracBits;
  localparam int unsigned AW  = $clog2(MAX_POINTS);
  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned GW  = $clog2(MAX_GROUPS + 2);
  localparam int unsigned QW  = ((COORD_BITS + 2 > bcc_pkg::StartQBits) ?
                                 COORD_BITS + 2 : bcc_pkg::StartQBits) + 1;
  localparam int unsigned DW0 = COORD_BITS + FB + CW;
  localparam int unsigned DW  = (DW0 > QW) ? DW0 : QW;
  localparam int unsigned HW  = DW + 1;
  localparam int unsigned MW  = 2 * COORD_BITS + RB;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MIN, ST_KEY, ST_SUM, ST_DIVX, ST_DIVY, ST_DIVR
  } state_e;

  state_e                     state_q;
  logic [bcc_pkg::StartQBits-1:0] startq_q;
  logic [CW-1:0]              cnt_q, n_q, idx_q, pc_q;
  logic                       rdv_q, found_q, emit_q, more_q;
  logic [QW-1:0]              q_q;
  logic [HW-1:0]              hi_q, lo_q;
  logic [GW-1:0]              grp_q;
  logic [COORD_BITS-1:0]      min_q;
  logic [COORD_BITS+CW-1:0]   sx_q, sy_q;
  logic [RB+CW-1:0]           sr_q;
  logic [DW-1:0]              mx_q, my_q;

  logic                       div_start;
  logic [DW-1:0]              div_a, div_b, div_quot, div_rem;
  bcc_pkg::div_stat_t         div_stat;

  logic                       wr_en;
  logic [MW-1:0]              rdata;
  logic [COORD_BITS-1:0]      rx, ry;
  logic [RB-1:0]              rr;
  logic [HW-1:0]              x4;
  logic [HW-1:0]              bin_lo;
  logic                       accept, scan_end;

  logic                       valid_q, lastg_q;
  logic [bcc_pkg::MeanXYBits-1:0] ox_q, oy_q;
  logic [bcc_pkg::MeanRBits-1:0]  or_q;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign wr_en    = accept && (cnt_q < CW'(MAX_POINTS));
  assign busy_o   = (state_q != ST_IDLE);
  assign scan_end = (idx_q == n_q) && !rdv_q;

  assign rx = rdata[MW-1 -: COORD_BITS];
  assign ry = rdata[RB +: COORD_BITS];
  assign rr = rdata[RB-1:0];
  assign x4 = HW'({rx, 2'b00});

  // Lower edge of the bin that holds the current minimum, in quarter pixels.
  assign bin_lo = HW'({min_q, 2'b00}) - HW'(div_rem);

  bcc_ram #(
    .Width (MW),
    .Depth (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i ({x_coord_i, y_coord_i, radius_i}),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Divider operands are chosen by the step that launches it.
  always_comb begin
    div_start = 1'b0;
    div_a     = DW'({min_q, 2'b00});
    div_b     = DW'(q_q);
    case (state_q)
      ST_MIN: begin
        div_start = scan_end && found_q;
      end
      ST_SUM: begin
        div_start = scan_end;
        div_a     = DW'({sx_q, {FB{1'b0}}});
        div_b     = DW'(pc_q);
      end
      ST_DIVX: begin
        div_start = div_stat.done;
        div_a     = DW'({sy_q, {FB{1'b0}}});
        div_b     = DW'(pc_q);
      end
      ST_DIVY: begin
        div_start = div_stat.done;
        div_a     = DW'({sr_q, {FB{1'b0}}});
        div_b     = DW'(pc_q);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  bcc_div #(
    .Width (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      startq_q <= bcc_pkg::StartQReset;
      cnt_q    <= '0;
      n_q      <= '0;
      idx_q    <= '0;
      pc_q     <= '0;
      rdv_q    <= 1'b0;
      found_q  <= 1'b0;
      emit_q   <= 1'b0;
      more_q   <= 1'b0;
      q_q      <= '0;
      hi_q     <= '0;
      lo_q     <= '0;
      grp_q    <= '0;
      min_q    <= '0;
      sx_q     <= '0;
      sy_q     <= '0;
      sr_q     <= '0;
      mx_q     <= '0;
      my_q     <= '0;
      ox_q     <= '0;
      oy_q     <= '0;
      or_q     <= '0;
      valid_q  <= 1'b0;
      lastg_q  <= 1'b0;
    end else begin
      valid_q <= (state_q == ST_DIVR) && div_stat.done;
      if (cfg_we_i) begin
        startq_q <= cfg_wdata_i;
      end
      // Scan address walk shared by the min search and the sum pass.
      if (state_q == ST_MIN || state_q == ST_SUM) begin
        rdv_q <= (idx_q != n_q);
        if (idx_q != n_q) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (last_point_i) begin
              n_q     <= wr_en ? cnt_q + 1'b1 : cnt_q;
              cnt_q   <= '0;
              q_q     <= (startq_q == '0) ? QW'(1) : QW'(startq_q);
              hi_q    <= '0;
              grp_q   <= '0;
              emit_q  <= 1'b0;
              idx_q   <= '0;
              rdv_q   <= 1'b0;
              found_q <= 1'b0;
              state_q <= ST_MIN;
            end else if (wr_en) begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        ST_MIN: begin
          if (rdv_q && x4 >= hi_q && (!found_q || rx < min_q)) begin
            min_q   <= rx;
            found_q <= 1'b1;
          end
          if (scan_end) begin
            if (found_q) begin
              state_q <= ST_KEY;
            end else begin
              // Interval accepted: rescan from the lowest bin and emit.
              emit_q  <= 1'b1;
              hi_q    <= '0;
              idx_q   <= '0;
              state_q <= ST_MIN;
            end
          end
        end
        ST_KEY: begin
          if (div_stat.done) begin
            idx_q   <= '0;
            rdv_q   <= 1'b0;
            found_q <= 1'b0;
            if (emit_q) begin
              lo_q    <= bin_lo;
              hi_q    <= bin_lo + HW'(q_q);
              sx_q    <= '0;
              sy_q    <= '0;
              sr_q    <= '0;
              pc_q    <= '0;
              more_q  <= 1'b0;
              state_q <= ST_SUM;
            end else if (grp_q == GW'(MAX_GROUPS)) begin
              // One bin too many: widen the interval and count again.
              q_q     <= q_q + 1'b1;
              grp_q   <= '0;
              hi_q    <= '0;
              state_q <= ST_MIN;
            end else begin
              hi_q    <= bin_lo + HW'(q_q);
              grp_q   <= grp_q + 1'b1;
              state_q <= ST_MIN;
            end
          end
        end
        ST_SUM: begin
          if (rdv_q) begin
            if (x4 >= lo_q && x4 < hi_q) begin
              sx_q <= sx_q + (COORD_BITS+CW)'(rx);
              sy_q <= sy_q + (COORD_BITS+CW)'(ry);
              sr_q <= sr_q + (RB+CW)'(rr);
              pc_q <= pc_q + 1'b1;
            end
            if (x4 >= hi_q) begin
              more_q <= 1'b1;
            end
          end
          if (scan_end) begin
            state_q <= ST_DIVX;
          end
        end
        ST_DIVX: begin
          if (div_stat.done) begin
            mx_q    <= div_quot;
            state_q <= ST_DIVY;
          end
        end
        ST_DIVY: begin
          if (div_stat.done) begin
            my_q    <= div_quot;
            state_q <= ST_DIVR;
          end
        end
        ST_DIVR: begin
          if (div_stat.done) begin
            ox_q    <= bcc_pkg::MeanXYBits'(mx_q);
            oy_q    <= bcc_pkg::MeanXYBits'(my_q);
            or_q    <= bcc_pkg::MeanRBits'(div_quot);
            lastg_q <= !more_q;
            idx_q   <= '0;
            rdv_q   <= 1'b0;
            found_q <= 1'b0;
            state_q <= more_q ? ST_MIN : ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o     = valid_q;
  assign mean_x_o           = ox_q;
  assign mean_y_o           = oy_q;
  assign mean_radius_o      = or_q;
  assign final_interval_q_o = bcc_pkg::IntervalBits'(q_q);
  assign last_group_o       = lastg_q;

endmodule

>>> tb/tb_bin_points_column_centroids.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bin_points_column_centroids
// Loads sets of circle centres into the column binning block, including
// single points, field extremes and spread sets that force interval growth.
// A predictor sorts, bins and averages each set, and every centroid beat is
// checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_bin_points_column_centroids;

  localparam int unsigned NumPoints = 256;
  localparam int unsigned NumGroups = 24;
  localparam int unsigned CoordBits = 12;
  localparam int unsigned StartQMax = (1 << bcc_pkg::StartQBits) - 1;

  typedef struct {
    logic [CoordBits-1:0]           x;
    logic [CoordBits-1:0]           y;
    logic [bcc_pkg::RadiusBits-1:0] r;
    logic                           last;
  } point_t;

  typedef struct {
    logic [bcc_pkg::MeanXYBits-1:0]   mx;
    logic [bcc_pkg::MeanXYBits-1:0]   my;
    logic [bcc_pkg::MeanRBits-1:0]    mr;
    logic [bcc_pkg::IntervalBits-1:0] iq;
    logic                             lg;
  } centroid_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [CoordBits-1:0] x_coord_i = '0;
  logic [CoordBits-1:0] y_coord_i = '0;
  logic [bcc_pkg::RadiusBits-1:0] radius_i = '0;
  logic last_point_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [bcc_pkg::StartQBits-1:0] cfg_wdata_i = '0;
  logic result_valid_o;
  logic [bcc_pkg::MeanXYBits-1:0] mean_x_o, mean_y_o;
  logic [bcc_pkg::MeanRBits-1:0] mean_radius_o;
  logic [bcc_pkg::IntervalBits-1:0] final_interval_q_o;
  logic last_group_o;

  point_t    point_q[$];
  centroid_t centroid_q[$];

  // Predictor state.
  int unsigned start_q = 32'(bcc_pkg::StartQReset);
  int unsigned held;
  int unsigned px[NumPoints], py[NumPoints], pr[NumPoints], order_idx[NumPoints];

  bit beat_taken;
  bit no_idle;
  int gap_left;
  int errors, sets_sent, items_sent, results_seen;

  bin_points_column_centroids #(
    .MAX_POINTS(NumPoints),
    .MAX_GROUPS(NumGroups),
    .COORD_BITS(CoordBits)
  ) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .x_coord_i(x_coord_i), .y_coord_i(y_coord_i), .radius_i(radius_i),
    .last_point_i(last_point_i), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .result_valid_o(result_valid_o), .mean_x_o(mean_x_o), .mean_y_o(mean_y_o),
    .mean_radius_o(mean_radius_o), .final_interval_q_o(final_interval_q_o),
    .last_group_o(last_group_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint unsigned column_of(int unsigned x, longint unsigned q);
    return (4 * longint'(x)) / q;
  endfunction

  // Sorts the held set by x, widens the interval until the bins fit and
  // queues one centroid per occupied bin.
  task automatic bin_and_average(int unsigned n);
    longint unsigned q, prev, k, key, sx, sy, sr, cnt, groups;
    int unsigned v, j;
    centroid_t c;
    q = (start_q == 0) ? 1 : start_q;
    for (int i = 0; i < n; i++) order_idx[i] = i;
    for (int i = 1; i < n; i++) begin
      v = order_idx[i];
      j = i;
      while (j > 0 && px[order_idx[j-1]] > px[v]) begin
        order_idx[j] = order_idx[j-1];
        j--;
      end
      order_idx[j] = v;
    end
    forever begin
      groups = 1;
      prev = column_of(px[order_idx[0]], q);
      for (int i = 1; i < n; i++) begin
        k = column_of(px[order_idx[i]], q);
        if (k != prev) begin
          groups++;
          prev = k;
        end
      end
      if (groups <= NumGroups) break;
      q++;
    end
    cnt = 0; sx = 0; sy = 0; sr = 0; key = 0;
    for (int i = 0; i < n; i++) begin
      if (cnt == 0) key = column_of(px[order_idx[i]], q);
      sx += px[order_idx[i]];
      sy += py[order_idx[i]];
      sr += pr[order_idx[i]];
      cnt++;
      if (i + 1 == n || column_of(px[order_idx[i+1]], q) != key) begin
        c.mx = bcc_pkg::MeanXYBits'((sx * 16) / cnt);
        c.my = bcc_pkg::MeanXYBits'((sy * 16) / cnt);
        c.mr = bcc_pkg::MeanRBits'((sr * 16) / cnt);
        c.iq = q[bcc_pkg::IntervalBits-1:0];
        c.lg = (i + 1 == n);
        centroid_q = {centroid_q, c};
        cnt = 0; sx = 0; sy = 0; sr = 0;
      end
    end
  endtask

  task automatic take_point(point_t p);
    int unsigned n;
    if (held < NumPoints) begin
      px[held] = 32'(p.x);
      py[held] = 32'(p.y);
      pr[held] = 32'(p.r);
      held++;
    end
    if (p.last) begin
      n = held;
      held = 0;
      if (n > 0) bin_and_average(n);
    end
  endtask

  always @(negedge clk_i) begin : drive
    point_t p;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && !beat_taken) begin
      // Beat not yet taken: hold everything.
    end else if (gap_left > 0) begin
      start_i <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (point_q.size() > 0) begin
      p = point_q.pop_front();
      x_coord_i <= p.x;
      y_coord_i <= p.y;
      radius_i <= p.r;
      last_point_i <= p.last;
      start_i <= 1'b1;
      if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
      gap_left <= no_idle ? 0 : $urandom_range(0, 16);
    end else begin
      start_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : watch
    point_t p;
    centroid_t c;
    beat_taken = rst_ni && start_i && !busy_o;
    if (beat_taken) begin
      p.x = x_coord_i;
      p.y = y_coord_i;
      p.r = radius_i;
      p.last = last_point_i;
      take_point(p);
    end
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (centroid_q.size() == 0) begin
        $error("unexpected centroid beat: mean_x %0d mean_y %0d", mean_x_o, mean_y_o);
        errors++;
      end else begin
        c = centroid_q.pop_front();
        if (mean_x_o !== c.mx) begin
          $error("mean_x: expected %0d, got %0d", c.mx, mean_x_o);
          errors++;
        end
        if (mean_y_o !== c.my) begin
          $error("mean_y: expected %0d, got %0d", c.my, mean_y_o);
          errors++;
        end
        if (mean_radius_o !== c.mr) begin
          $error("mean_radius: expected %0d, got %0d", c.mr, mean_radius_o);
          errors++;
        end
        if (final_interval_q_o !== c.iq) begin
          $error("final_interval_q: expected %0d, got %0d", c.iq, final_interval_q_o);
          errors++;
        end
        if (last_group_o !== c.lg) begin
          $error("last_group: expected %0d, got %0d", c.lg, last_group_o);
          errors++;
        end
      end
    end
  end

  task automatic add_point(int unsigned x, int unsigned y, int unsigned r, bit last);
    point_t p;
    p.x = CoordBits'(x);
    p.y = CoordBits'(y);
    p.r = bcc_pkg::RadiusBits'(r);
    p.last = last;
    point_q = {point_q, p};
    items_sent++;
    if (last) sets_sent++;
  endtask

  // A set of n points whose x values lie within span pixels of a random base.
  task automatic add_set(int unsigned n, int unsigned span);
    int unsigned base;
    base = $urandom_range(0, (1 << CoordBits) - 1 - span);
    for (int i = 0; i < n; i++)
      add_point(base + $urandom_range(0, span), $urandom_range(0, 4095),
                $urandom_range(0, 63), i == n - 1);
  endtask

  // Points about 40 pixels apart in shuffled order, so that narrow widths
  // see more columns than there are bins.
  task automatic add_spread(int unsigned n);
    for (int i = 0; i < n; i++)
      add_point(40 * ((i * 11) % n) + $urandom_range(0, 3), $urandom_range(0, 4095),
                $urandom_range(0, 63), i == n - 1);
  endtask

  task automatic drain;
    wait (point_q.size() == 0 && !start_i);
    wait (centroid_q.size() == 0);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_start_q(int unsigned val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= bcc_pkg::StartQBits'(val);
    start_q = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    #(50_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned phase_items, n, cfg_list[5];
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed sets at the reset width of 11 pixels.
    add_point(0, 0, 0, 1'b1);
    add_point(4095, 4095, 63, 1'b1);
    add_point(10, 5, 1, 1'b0);
    add_point(11, 4095, 62, 1'b0);
    add_point(0, 100, 7, 1'b1);
    add_point(4095, 1, 3, 1'b0);
    add_point(2048, 2047, 32, 1'b0);
    add_point(1365, 2730, 21, 1'b0);
    add_point(2730, 1365, 42, 1'b1);
    drain();
    // A start width of zero acts as one quarter pixel.
    write_start_q(0);
    add_point(2, 9, 5, 1'b0);
    add_point(0, 3, 6, 1'b0);
    add_point(1, 4, 7, 1'b0);
    add_point(1, 4095, 63, 1'b1);
    drain();
    write_start_q(StartQMax);
    add_point(0, 0, 63, 1'b0);
    add_point(4095, 4095, 0, 1'b0);
    add_point(3000, 17, 9, 1'b1);
    drain();

    cfg_list = '{1, StartQMax, $urandom_range(2, 120), 32'(bcc_pkg::StartQReset),
                 $urandom_range(200, StartQMax)};
    foreach (cfg_list[i]) begin
      write_start_q(cfg_list[i]);
      phase_items = 0;
      if (cfg_list[i] <= 120) begin
        // Enough distinct columns to force the interval to widen.
        n = $urandom_range(25, 27);
        add_spread(n);
        phase_items += n;
      end
      while (phase_items < 22) begin
        n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 22 - phase_items);
        add_set(n, $urandom_range(0, 300));
        phase_items += n;
      end
      drain();
    end

    $display("Sent %0d sets (%0d points) over 8 start widths; %0d centroid beats checked.",
             sets_sent, items_sent, results_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
